>>> design/rtte_pkg.sv
// Shared widths, register indexes and reset values for the RTT estimator.
// No dependencies.
package rtte_pkg;

    localparam int SAMPLE_W   = 48;
    localparam int TIME_OUT_W = 47;
    localparam int CNT_OUT_W  = 32;
    localparam int CFG_W      = 47;
    localparam int CFG_IDX_W  = 1;
    localparam int TDATA_W    = 176;   // 3 x 47 + 32 = 173, padded to whole bytes

    localparam logic [CFG_W-1:0]     MIN_DEADLINE_RST = 47'd1000000000;
    localparam logic [CFG_W-1:0]     MAX_DEADLINE_RST = 47'd30000000000;
    localparam logic [CNT_OUT_W-1:0] CNT_OUT_MAX      = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_DEADLINE = 1'b0,
        REG_MAX_DEADLINE = 1'b1
    } cfg_reg_t;

endpackage

>>> design/rtt_estimator_deadline_top.sv
// RTT estimator (smoothed RTT, variation, sample count) with deadline allowance.
// Depends on rtte_pkg.
//
//  channel | dir | handshake                     | payload
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata: rtt_sample
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tdata: srtt, rttvar, allowance, count
//          |     |                               | tuser: sample_taken
//  cfg     | in  | cfg_we (no wait)              | cfg_index, cfg_data
//
// One item per cycle sustained while m_axis_tready stays high; the result is registered.
// Stages: input register (sample clamp), estimate update into state and a snapshot
// register, then allowance sum and clamp into the output register.
// Reset clears the estimates and count and loads the default deadline limits.
// A stalled output holds the pipeline back one stage at a time; empty stages still fill.
module rtt_estimator_deadline_top
    import rtte_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [SAMPLE_W-1:0]     s_axis_tdata,   // [46:0] rtt_sample, [47] skip flag (sample taken when low)
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // [46:0] smoothed_rtt,
                                                    // [93:47] rtt_variation,
                                                    // [140:94] deadline_allowance,
                                                    // [172:141] sample_count, rest zero
    output logic                    m_axis_tuser,   // [0] sample_taken
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    localparam int MW  = TIME_BITS - 1;                 // non-negative estimate width
    localparam int DW  = MW + 2;                        // signed difference width
    localparam int CW  = (TIME_BITS > SAMPLE_W) ? TIME_BITS : SAMPLE_W;
    localparam int BW  = MW + 3;                        // srtt + 4*rttvar
    localparam int AW  = (BW > CFG_W) ? BW : CFG_W;
    localparam int CXW = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
    localparam logic [CW-1:0] POS_MAX = CW'({MW{1'b1}});

    // configuration
    logic [CFG_W-1:0] min_reg, max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_DEADLINE_RST;
            max_reg <= MAX_DEADLINE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_DEADLINE: min_reg <= cfg_data;
                REG_MAX_DEADLINE: max_reg <= cfg_data;
                default:          min_reg <= min_reg;
            endcase
        end
    end

    // handshake chain
    logic in_valid_reg, mid_valid_reg, out_valid_reg;
    logic c_ready, b_ready, a_ready;
    logic a_load, b_load, c_load;

    assign c_ready = !out_valid_reg || m_axis_tready;
    assign b_ready = !mid_valid_reg || c_ready;
    assign a_ready = !in_valid_reg || b_ready;
    assign s_axis_tready = a_ready;

    assign a_load = s_axis_tvalid && a_ready;
    assign b_load = in_valid_reg && b_ready;
    assign c_load = mid_valid_reg && c_ready;

    // stage A: sample clamp
    logic [CW-1:0] raw_ext, max_ext, limit, clamped;
    logic [MW-1:0] in_ns_reg;
    logic          in_taken_reg;

    always_comb
    begin
        raw_ext = CW'(s_axis_tdata[SAMPLE_W-2:0]);
        max_ext = CW'(max_reg);
        limit   = (max_ext > POS_MAX) ? POS_MAX : max_ext;
        clamped = (raw_ext > limit) ? limit : raw_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (a_ready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            in_ns_reg    <= clamped[MW-1:0];
            in_taken_reg <= !s_axis_tdata[SAMPLE_W-1];
        end
    end

    // stage B: estimate update
    logic [MW-1:0]         srtt_reg, rttvar_reg, srtt_next, rttvar_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic signed [DW-1:0]  diff, diff_b, dv, dv_b, q4, q8, v_sum, s_sum;
    logic [MW-1:0]         dev;

    always_comb
    begin
        diff   = $signed({2'b00, in_ns_reg}) - $signed({2'b00, srtt_reg});
        dev    = diff[DW-1] ? MW'(-diff) : diff[MW-1:0];
        dv     = $signed({2'b00, dev}) - $signed({2'b00, rttvar_reg});
        dv_b   = dv + (dv[DW-1] ? DW'(3) : DW'(0));
        q4     = dv_b >>> 2;
        diff_b = diff + (diff[DW-1] ? DW'(7) : DW'(0));
        q8     = diff_b >>> 3;
        v_sum  = $signed({2'b00, rttvar_reg}) + q4;
        s_sum  = $signed({2'b00, srtt_reg}) + q8;

        srtt_next   = srtt_reg;
        rttvar_next = rttvar_reg;
        cnt_next    = cnt_reg;
        if (in_taken_reg)
        begin
            if (cnt_reg == '0)
            begin
                srtt_next   = in_ns_reg;
                rttvar_next = in_ns_reg >> 1;
            end
            else
            begin
                srtt_next   = s_sum[MW-1:0];
                rttvar_next = v_sum[MW-1:0];
            end
            if (cnt_reg != '1)
                cnt_next = cnt_reg + COUNT_BITS'(1);
        end
    end

    logic [MW-1:0]         mid_srtt_reg, mid_rttvar_reg;
    logic [COUNT_BITS-1:0] mid_cnt_reg;
    logic                  mid_taken_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srtt_reg      <= '0;
            rttvar_reg    <= '0;
            cnt_reg       <= '0;
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_load)
            begin
                srtt_reg   <= srtt_next;
                rttvar_reg <= rttvar_next;
                cnt_reg    <= cnt_next;
            end
            if (b_ready)
                mid_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            mid_srtt_reg   <= srtt_next;
            mid_rttvar_reg <= rttvar_next;
            mid_cnt_reg    <= cnt_next;
            mid_taken_reg  <= in_taken_reg;
        end
    end

    // stage C: allowance and output register
    logic [AW-1:0]  base, min_ext, maxc_ext, allow, srtt_ext, rttvar_ext;
    logic [CXW-1:0] cnt_ext;
    logic [CNT_OUT_W-1:0] cnt_out;

    always_comb
    begin
        base       = AW'({2'b00, mid_srtt_reg}) + AW'({mid_rttvar_reg, 2'b00});
        min_ext    = AW'(min_reg);
        maxc_ext   = AW'(max_reg);
        srtt_ext   = AW'(mid_srtt_reg);
        rttvar_ext = AW'(mid_rttvar_reg);
        if (mid_cnt_reg == '0)
            allow = min_ext;
        else if (base <= min_ext)
            allow = min_ext;
        else if (base >= maxc_ext)
            allow = maxc_ext;
        else
            allow = base;
        cnt_ext = CXW'(mid_cnt_reg);
        cnt_out = (cnt_ext > CXW'(CNT_OUT_MAX)) ? CNT_OUT_MAX : cnt_ext[CNT_OUT_W-1:0];
    end

    logic [TDATA_W-1:0] out_data_reg;
    logic               out_taken_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (c_ready)
            out_valid_reg <= mid_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (c_load)
        begin
            out_data_reg  <= TDATA_W'({cnt_out, allow[TIME_OUT_W-1:0],
                                       rttvar_ext[TIME_OUT_W-1:0],
                                       srtt_ext[TIME_OUT_W-1:0]});
            out_taken_reg <= mid_taken_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_taken_reg;

    // checks
    a_first_half: assert property (@(posedge clk) disable iff (!rst_n)
        b_load && in_taken_reg && (cnt_reg == '0) |=>
            mid_rttvar_reg == (mid_srtt_reg >> 1))
        else $error("first sample did not set variation to half the estimate");

    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> cnt_reg >= $past(cnt_reg))
        else $error("sample count went backwards");

    a_taken_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_taken_reg |-> out_data_reg[TDATA_W-4:3*TIME_OUT_W] != '0)
        else $error("folded sample reported with zero count");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !b_ready |=> in_valid_reg && $stable(in_ns_reg))
        else $error("stalled item lost in the input stage");

endmodule
